// ===== hdl/ppr_pkg.sv =====
`timescale 1ns / 1ps
package ppr_pkg;

  // Field and fixed-point formats
  localparam int COORD_W    = 32;
  localparam int ROT_FRAC   = 30;
  localparam int NORM_FRAC  = 24;

  // Configuration register file
  localparam int NUM_REGS   = 8;
  localparam int REG_IDX_W  = $clog2(NUM_REGS);
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 64;

  localparam int REG_ROT_A           = 0;
  localparam int REG_ROT_B           = 1;
  localparam int REG_ROT_C           = 2;
  localparam int REG_TRANS_XY        = 3;
  localparam int REG_TRANS_Z_FOCAL_X = 4;
  localparam int REG_SKEW_FOCAL_Y    = 5;
  localparam int REG_PRINCIPAL_POINT = 6;
  localparam int REG_RADIAL_COEFFS   = 7;

  localparam logic [CFG_DATA_W-1:0] REG_RESET [NUM_REGS] = '{
    64'h4000_0000_0000_0000,
    64'h0000_0000_0000_0000,
    64'h4000_0000_0000_0000,
    64'h0000_0000_0000_0000,
    64'h0001_0000_0001_0000,
    64'h0000_0000_0001_0000,
    64'h0000_0000_0000_0000,
    64'h0000_0000_0000_0000
  };

  // Internal widths
  localparam int CAMW  = 36;                 // camera coordinate, signed
  localparam int MAGW  = CAMW - 1;           // magnitude of a camera coordinate
  localparam int NUMW  = MAGW + NORM_FRAC;   // dividend magnitude
  localparam int QBITS = 31;                 // quotient bits below saturation
  localparam int DSW   = MAGW + QBITS;       // divisor aligned to the top bit
  localparam int OVFW  = MAGW + 7;           // width of the overflow compare
  localparam int SATW  = 68;                 // headroom for sums before saturation
  localparam int KTW   = 42;                 // rounded k * r term

  localparam logic signed [COORD_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [SATW-1:0]    ONE_Q24 = SATW'(1) <<< NORM_FRAC;

  typedef struct packed {
    logic signed [COORD_W-1:0] r00, r10, r20, r01, r11, r21;
    logic signed [COORD_W-1:0] tx, ty, tz;
    logic signed [COORD_W-1:0] alpha, gamma, beta, u0, v0;
    logic signed [COORD_W-1:0] k1, k2;
  } ppr_cfg_t;

  typedef struct packed {
    logic valid;
    logic clamped;
  } ppr_ctl_t;

  typedef struct packed {
    ppr_ctl_t         ctl;
    logic             neg_x;
    logic             neg_y;
    logic             ovf_x;
    logic             ovf_y;
    logic [MAGW-1:0]  dmag;
    logic [NUMW-1:0]  rem_x;
    logic [NUMW-1:0]  rem_y;
    logic [QBITS-1:0] q_x;
    logic [QBITS-1:0] q_y;
  } ppr_div_t;

  // Round to nearest, ties toward +inf, then drop n fraction bits
  function automatic logic signed [SATW-1:0] rnd(input logic signed [SATW-1:0] v,
                                                 input int n);
    return (v + (SATW'(1) <<< (n - 1))) >>> n;
  endfunction

  // Clamp to the symmetric 32-bit range
  function automatic logic signed [COORD_W-1:0] sat32(input logic signed [SATW-1:0] v);
    logic signed [COORD_W-1:0] res;
    if (v > SATW'(SAT_MAX)) begin
      res = SAT_MAX;
    end else if (v < -SATW'(SAT_MAX)) begin
      res = -SAT_MAX;
    end else begin
      res = v[COORD_W-1:0];
    end
    return res;
  endfunction

endpackage

// ===== hdl/ppr_in_if.sv =====
`timescale 1ns / 1ps
interface ppr_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [ppr_pkg::COORD_W-1:0]  point_x;
  logic signed [ppr_pkg::COORD_W-1:0]  point_y;

  modport source (output valid, point_x, point_y, input ready);
  modport sink   (input valid, point_x, point_y, output ready);
endinterface

// ===== hdl/ppr_out_if.sv =====
`timescale 1ns / 1ps
interface ppr_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [ppr_pkg::COORD_W-1:0]  pixel_u;
  logic signed [ppr_pkg::COORD_W-1:0]  pixel_v;
  logic                                depth_clamped;

  modport source (output valid, pixel_u, pixel_v, depth_clamped, input ready);
  modport sink   (input valid, pixel_u, pixel_v, depth_clamped, output ready);
endinterface

// ===== hdl/ppr_cfg_if.sv =====
`timescale 1ns / 1ps
interface ppr_cfg_if;
  logic                                  valid;
  logic                                  ready;
  logic [ppr_pkg::CFG_IDX_W-1:0]         index;
  logic [ppr_pkg::CFG_DATA_W-1:0]        data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/ppr_camera.sv =====
`timescale 1ns / 1ps
module ppr_camera (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               adv,
  input  ppr_pkg::ppr_cfg_t                  cfg,
  input  logic                               in_valid,
  input  logic signed [ppr_pkg::COORD_W-1:0] in_x,
  input  logic signed [ppr_pkg::COORD_W-1:0] in_y,
  output ppr_pkg::ppr_div_t                  div_o
);
  import ppr_pkg::*;

  logic                   v1_r, v2_r;
  logic signed [63:0]     prod_r [6];
  logic signed [CAMW-1:0] xc_r, yc_r, zc_r;
  logic signed [CAMW-1:0] xc_nxt, yc_nxt, zc_nxt;
  logic signed [CAMW-1:0] zc_fix;
  logic [MAGW-1:0]        xmag, ymag, dmag;
  ppr_div_t               div_nxt, div_r;

  // Rotation products
  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r[0] <= cfg.r00 * in_x;
      prod_r[1] <= cfg.r01 * in_y;
      prod_r[2] <= cfg.r10 * in_x;
      prod_r[3] <= cfg.r11 * in_y;
      prod_r[4] <= cfg.r20 * in_x;
      prod_r[5] <= cfg.r21 * in_y;
    end
  end

  // Camera coordinates
  assign xc_nxt = CAMW'(rnd(SATW'(prod_r[0]), ROT_FRAC) + rnd(SATW'(prod_r[1]), ROT_FRAC)
                        + SATW'(cfg.tx));
  assign yc_nxt = CAMW'(rnd(SATW'(prod_r[2]), ROT_FRAC) + rnd(SATW'(prod_r[3]), ROT_FRAC)
                        + SATW'(cfg.ty));
  assign zc_nxt = CAMW'(rnd(SATW'(prod_r[4]), ROT_FRAC) + rnd(SATW'(prod_r[5]), ROT_FRAC)
                        + SATW'(cfg.tz));

  always_ff @(posedge clk) begin
    if (adv) begin
      xc_r <= xc_nxt;
      yc_r <= yc_nxt;
      zc_r <= zc_nxt;
    end
  end

  // Clamp zero depth, split signs and magnitudes for the divider
  always_comb begin
    zc_fix = (zc_r == '0) ? CAMW'(1) : zc_r;
    xmag   = xc_r[CAMW-1] ? MAGW'(-xc_r) : MAGW'(xc_r);
    ymag   = yc_r[CAMW-1] ? MAGW'(-yc_r) : MAGW'(yc_r);
    dmag   = zc_fix[CAMW-1] ? MAGW'(-zc_fix) : MAGW'(zc_fix);

    div_nxt             = '0;
    div_nxt.ctl.valid   = v2_r;
    div_nxt.ctl.clamped = (zc_r == '0);
    div_nxt.neg_x       = xc_r[CAMW-1] ^ zc_fix[CAMW-1];
    div_nxt.neg_y       = yc_r[CAMW-1] ^ zc_fix[CAMW-1];
    div_nxt.ovf_x       = OVFW'(xmag) >= {dmag, 7'b0};
    div_nxt.ovf_y       = OVFW'(ymag) >= {dmag, 7'b0};
    div_nxt.dmag        = dmag;
    div_nxt.rem_x       = {xmag, {NORM_FRAC{1'b0}}};
    div_nxt.rem_y       = {ymag, {NORM_FRAC{1'b0}}};
  end

  // Advance valid bits and the divider setup
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r            <= 1'b0;
      v2_r            <= 1'b0;
      div_r.ctl.valid <= 1'b0;
    end else if (adv) begin
      v1_r  <= in_valid;
      v2_r  <= v1_r;
      div_r <= div_nxt;
    end
  end

  assign div_o = div_r;

endmodule

// ===== hdl/ppr_divider.sv =====
`timescale 1ns / 1ps
module ppr_divider (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  ppr_pkg::ppr_div_t div_i,
  output ppr_pkg::ppr_div_t div_o
);
  import ppr_pkg::*;

  ppr_div_t st   [QBITS+1];
  ppr_div_t st_r [QBITS];

  assign st[0] = div_i;

  // One restoring step per stage, shared divisor for both coordinates
  for (genvar i = 0; i < QBITS; i++) begin : g_stage
    localparam int B = QBITS - 1 - i;
    ppr_div_t       nxt;
    logic [DSW-1:0] dsh;

    always_comb begin
      nxt = st[i];
      dsh = DSW'(st[i].dmag) << B;
      if (DSW'(st[i].rem_x) >= dsh) begin
        nxt.rem_x  = st[i].rem_x - NUMW'(dsh);
        nxt.q_x[B] = 1'b1;
      end
      if (DSW'(st[i].rem_y) >= dsh) begin
        nxt.rem_y  = st[i].rem_y - NUMW'(dsh);
        nxt.q_y[B] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_r[i].ctl.valid <= 1'b0;
      end else if (adv) begin
        st_r[i] <= nxt;
      end
    end

    assign st[i+1] = st_r[i];
  end

  assign div_o = st[QBITS];

  // Remainders end below the divisor and the divisor is never zero
  a_rem_x: assert property (@(posedge clk) disable iff (!rst_n)
    (div_o.ctl.valid && !div_o.ovf_x) |-> (div_o.rem_x < NUMW'(div_o.dmag)))
    else $error("x remainder not below divisor");
  a_rem_y: assert property (@(posedge clk) disable iff (!rst_n)
    (div_o.ctl.valid && !div_o.ovf_y) |-> (div_o.rem_y < NUMW'(div_o.dmag)))
    else $error("y remainder not below divisor");
  a_dmag: assert property (@(posedge clk) disable iff (!rst_n)
    div_i.ctl.valid |-> (div_i.dmag != '0))
    else $error("zero divisor entered the divider");

endmodule

// ===== hdl/ppr_distort.sv =====
`timescale 1ns / 1ps
module ppr_distort (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               adv,
  input  ppr_pkg::ppr_cfg_t                  cfg,
  input  ppr_pkg::ppr_div_t                  div_i,
  output ppr_pkg::ppr_ctl_t                  ctl_o,
  output logic signed [ppr_pkg::COORD_W-1:0] pixel_u,
  output logic signed [ppr_pkg::COORD_W-1:0] pixel_v
);
  import ppr_pkg::*;

  localparam int NST = 11;

  logic [NST-1:0]            vld_r, clp_r;
  logic [COORD_W-1:0]        qmag_x, qmag_y;
  logic signed [COORD_W-1:0] xn_nxt, yn_nxt;
  logic signed [COORD_W-1:0] xn_r [7];
  logic signed [COORD_W-1:0] yn_r [7];
  logic signed [63:0]        sqx_r, sqy_r, r4p_r, k1p_r, k2p_r, xdp_r, ydp_r;
  logic signed [63:0]        ap_r, gp_r, bp_r;
  logic signed [COORD_W-1:0] r2_r, r4_r, coeff_r, xd_r, yd_r, u_r, v_r;
  logic signed [KTW-1:0]     k1t_r, k1td_r;

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NST-2:0], div_i.ctl.valid};
    end
  end

  // Apply sign and saturation to the quotients
  always_comb begin
    qmag_x = div_i.ovf_x ? COORD_W'(SAT_MAX) : {1'b0, div_i.q_x};
    qmag_y = div_i.ovf_y ? COORD_W'(SAT_MAX) : {1'b0, div_i.q_y};
    xn_nxt = div_i.neg_x ? -$signed(qmag_x) : $signed(qmag_x);
    yn_nxt = div_i.neg_y ? -$signed(qmag_y) : $signed(qmag_y);
  end

  // Distortion and intrinsics, one multiply or one rounding sum per stage
  always_ff @(posedge clk) begin
    if (adv) begin
      clp_r <= {clp_r[NST-2:0], div_i.ctl.clamped};
      xn_r[0] <= xn_nxt;
      yn_r[0] <= yn_nxt;
      for (int k = 1; k < 7; k++) begin
        xn_r[k] <= xn_r[k-1];
        yn_r[k] <= yn_r[k-1];
      end
      sqx_r   <= xn_r[0] * xn_r[0];
      sqy_r   <= yn_r[0] * yn_r[0];
      r2_r    <= sat32(rnd(SATW'(sqx_r) + SATW'(sqy_r), NORM_FRAC));
      r4p_r   <= r2_r * r2_r;
      k1p_r   <= cfg.k1 * r2_r;
      r4_r    <= sat32(rnd(SATW'(r4p_r), NORM_FRAC));
      k1t_r   <= KTW'(rnd(SATW'(k1p_r), NORM_FRAC));
      k2p_r   <= cfg.k2 * r4_r;
      k1td_r  <= k1t_r;
      coeff_r <= sat32(ONE_Q24 + SATW'(k1td_r) + rnd(SATW'(k2p_r), NORM_FRAC));
      xdp_r   <= xn_r[6] * coeff_r;
      ydp_r   <= yn_r[6] * coeff_r;
      xd_r    <= sat32(rnd(SATW'(xdp_r), NORM_FRAC));
      yd_r    <= sat32(rnd(SATW'(ydp_r), NORM_FRAC));
      ap_r    <= cfg.alpha * xd_r;
      gp_r    <= cfg.gamma * yd_r;
      bp_r    <= cfg.beta * yd_r;
      u_r     <= sat32(rnd(SATW'(ap_r), NORM_FRAC) + rnd(SATW'(gp_r), NORM_FRAC)
                       + SATW'(cfg.u0));
      v_r     <= sat32(rnd(SATW'(bp_r), NORM_FRAC) + SATW'(cfg.v0));
    end
  end

  assign ctl_o.valid   = vld_r[NST-1];
  assign ctl_o.clamped = clp_r[NST-1];
  assign pixel_u       = u_r;
  assign pixel_v       = v_r;

endmodule

// ===== hdl/pinhole_projection_radial_distortion.sv =====
`timescale 1ns / 1ps
// Channel  Dir  Payload                                  Handshake
// in_ch    in   point_x, point_y (Q16.16)                valid/ready
// out_ch   out  pixel_u, pixel_v (Q16.16), depth_clamped valid/ready
// cfg_ch   in   index (8b), data (64b)                   valid/ready, always ready
//
// One item per cycle unless the pipeline holds; each item passes through these stages to the output register:
// 3 camera stages, 31 stages of the restoring divider (one quotient bit each),
// 11 distortion and intrinsic stages, the last being the output register.
// Synchronous active-low reset clears valid bits and loads register defaults.
// The whole pipeline holds while the output register is full and not taken.
module pinhole_projection_radial_distortion (
  input  logic      clk,
  input  logic      rst_n,
  ppr_in_if.sink    in_ch,
  ppr_out_if.source out_ch,
  ppr_cfg_if.sink   cfg_ch
);
  import ppr_pkg::*;

  logic [CFG_DATA_W-1:0] regs_r [NUM_REGS];
  ppr_cfg_t              cfg;
  ppr_div_t              div_in, div_out;
  ppr_ctl_t              ctl;
  logic                  adv;

  // Register file writes
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        regs_r[i] <= REG_RESET[i];
      end
    end else if (cfg_ch.valid && cfg_ch.ready && (cfg_ch.index < CFG_IDX_W'(NUM_REGS))) begin
      regs_r[cfg_ch.index[REG_IDX_W-1:0]] <= cfg_ch.data;
    end
  end

  // Unpack register halves
  always_comb begin
    cfg.r00   = regs_r[REG_ROT_A][63:32];
    cfg.r10   = regs_r[REG_ROT_A][31:0];
    cfg.r20   = regs_r[REG_ROT_B][63:32];
    cfg.r01   = regs_r[REG_ROT_B][31:0];
    cfg.r11   = regs_r[REG_ROT_C][63:32];
    cfg.r21   = regs_r[REG_ROT_C][31:0];
    cfg.tx    = regs_r[REG_TRANS_XY][63:32];
    cfg.ty    = regs_r[REG_TRANS_XY][31:0];
    cfg.tz    = regs_r[REG_TRANS_Z_FOCAL_X][63:32];
    cfg.alpha = regs_r[REG_TRANS_Z_FOCAL_X][31:0];
    cfg.gamma = regs_r[REG_SKEW_FOCAL_Y][63:32];
    cfg.beta  = regs_r[REG_SKEW_FOCAL_Y][31:0];
    cfg.u0    = regs_r[REG_PRINCIPAL_POINT][63:32];
    cfg.v0    = regs_r[REG_PRINCIPAL_POINT][31:0];
    cfg.k1    = regs_r[REG_RADIAL_COEFFS][63:32];
    cfg.k2    = regs_r[REG_RADIAL_COEFFS][31:0];
  end

  // Advance everything unless the output register is held
  assign adv         = !ctl.valid || out_ch.ready;
  assign in_ch.ready = adv;

  ppr_camera u_camera (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .cfg      (cfg),
    .in_valid (in_ch.valid),
    .in_x     (in_ch.point_x),
    .in_y     (in_ch.point_y),
    .div_o    (div_in)
  );

  ppr_divider u_divider (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .div_i (div_in),
    .div_o (div_out)
  );

  ppr_distort u_distort (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .cfg     (cfg),
    .div_i   (div_out),
    .ctl_o   (ctl),
    .pixel_u (out_ch.pixel_u),
    .pixel_v (out_ch.pixel_v)
  );

  assign out_ch.valid         = ctl.valid;
  assign out_ch.depth_clamped = ctl.clamped;

endmodule

// ===== tb/sv/pinhole_projection_radial_distortion_tb.sv =====
`timescale 1ns / 1ps
module pinhole_projection_radial_distortion_tb;
  import ppr_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 60;
  localparam logic [CFG_IDX_W-1:0] IDX_PAST_END = CFG_IDX_W'(NUM_REGS);
  localparam logic [CFG_IDX_W-1:0] IDX_TOP      = '1;

  typedef struct {
    logic signed [COORD_W-1:0] u;
    logic signed [COORD_W-1:0] v;
    logic                      clamped;
  } pixel_t;

  // Projection predictor and store of expected pixels
  class ProjectionScoreboard;
    logic [CFG_DATA_W-1:0] regs [NUM_REGS];
    pixel_t pixels_due [$];
    int errors;
    int points;
    int clamps;

    function new();
      for (int i = 0; i < NUM_REGS; i++) regs[i] = REG_RESET[i];
      errors = 0;
      points = 0;
      clamps = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
      if (idx < NUM_REGS) regs[idx] = d;
    endfunction

    function longint half(int idx, bit upper);
      logic [31:0] w;
      w = upper ? regs[idx][63:32] : regs[idx][31:0];
      return longint'($signed(w));
    endfunction

    function longint round_shift(longint v, int n);
      return (v + (longint'(1) <<< (n - 1))) >>> n;
    endfunction

    function longint clip(longint v);
      longint lim;
      lim = 64'sd2147483647;
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
    endfunction

    // Project one point with the current camera setup
    function pixel_t project(logic signed [31:0] x, logic signed [31:0] y);
      longint px, py, xc, yc, zc, xn, yn, r2, r4, coeff, xd, yd, u, v;
      pixel_t p;
      px = longint'(x);
      py = longint'(y);
      p.clamped = 1'b0;
      xc = round_shift(half(REG_ROT_A, 1) * px, ROT_FRAC)
         + round_shift(half(REG_ROT_B, 0) * py, ROT_FRAC) + half(REG_TRANS_XY, 1);
      yc = round_shift(half(REG_ROT_A, 0) * px, ROT_FRAC)
         + round_shift(half(REG_ROT_C, 1) * py, ROT_FRAC) + half(REG_TRANS_XY, 0);
      zc = round_shift(half(REG_ROT_B, 1) * px, ROT_FRAC)
         + round_shift(half(REG_ROT_C, 0) * py, ROT_FRAC)
         + half(REG_TRANS_Z_FOCAL_X, 1);
      // replace zero depth by one LSB
      if (zc == 0) begin
        zc = 1;
        p.clamped = 1'b1;
      end
      xn = clip((xc * (longint'(1) <<< NORM_FRAC)) / zc);
      yn = clip((yc * (longint'(1) <<< NORM_FRAC)) / zc);
      r2 = clip(round_shift(xn * xn + yn * yn, NORM_FRAC));
      r4 = clip(round_shift(r2 * r2, NORM_FRAC));
      coeff = clip((longint'(1) <<< NORM_FRAC)
                   + round_shift(half(REG_RADIAL_COEFFS, 1) * r2, NORM_FRAC)
                   + round_shift(half(REG_RADIAL_COEFFS, 0) * r4, NORM_FRAC));
      xd = clip(round_shift(xn * coeff, NORM_FRAC));
      yd = clip(round_shift(yn * coeff, NORM_FRAC));
      u = clip(round_shift(half(REG_TRANS_Z_FOCAL_X, 0) * xd, NORM_FRAC)
               + round_shift(half(REG_SKEW_FOCAL_Y, 1) * yd, NORM_FRAC)
               + half(REG_PRINCIPAL_POINT, 1));
      v = clip(round_shift(half(REG_SKEW_FOCAL_Y, 0) * yd, NORM_FRAC)
               + half(REG_PRINCIPAL_POINT, 0));
      p.u = u[31:0];
      p.v = v[31:0];
      return p;
    endfunction

    function void note_point(logic signed [31:0] x, logic signed [31:0] y);
      pixel_t p;
      p = project(x, y);
      points++;
      if (p.clamped) clamps++;
      pixels_due.insert(pixels_due.size(), p);
    endfunction

    function void check_pixel(logic signed [31:0] u, logic signed [31:0] v, logic c);
      pixel_t p;
      if (pixels_due.size() == 0) begin
        $display("%0t: unexpected pixel u=%0d v=%0d clamped=%0b", $time, u, v, c);
        errors++;
        return;
      end
      p = pixels_due.pop_front();
      if (u !== p.u) begin
        $display("%0t: pixel_u expected %0d got %0d", $time, p.u, u);
        errors++;
      end
      if (v !== p.v) begin
        $display("%0t: pixel_v expected %0d got %0d", $time, p.v, v);
        errors++;
      end
      if (c !== p.clamped) begin
        $display("%0t: depth_clamped expected %0b got %0b", $time, p.clamped, c);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  ppr_in_if  in_ch ();
  ppr_out_if out_ch ();
  ppr_cfg_if cfg_ch ();

  ProjectionScoreboard sb;
  bit  idle_on;
  int  settings;
  int  quiet_cycles;
  logic signed [31:0] edge_vals [8];

  pinhole_projection_radial_distortion dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Send one point, honoring the random gap
  task automatic send_point(logic signed [31:0] x, logic signed [31:0] y);
    int gap;
    gap = idle_on ? $urandom_range(0, 8) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid   <= 1'b1;
    in_ch.point_x <= x;
    in_ch.point_y <= y;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_point(x, y);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= d;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    sb.write_reg(idx, d);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Drop valid and wait until every pixel is back and the pipe is empty
  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.pixels_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] span(int lo, int hi);
    return 32'($urandom_range(0, hi - lo)) + 32'(lo);
  endfunction

  // Plausible camera value for one register
  function automatic logic [63:0] camera_reg(int idx);
    case (idx)
      REG_ROT_A, REG_ROT_B, REG_ROT_C: begin
        return {span(-(1 << 30), 1 << 30), span(-(1 << 30), 1 << 30)};
      end
      REG_TRANS_XY: begin
        return {span(-(20 << 16), 20 << 16), span(-(20 << 16), 20 << 16)};
      end
      REG_TRANS_Z_FOCAL_X: begin
        return {span(1 << 16, 200 << 16), span(1 << 16, 2000 << 16)};
      end
      REG_SKEW_FOCAL_Y: begin
        return {span(-(4 << 16), 4 << 16), span(1 << 16, 2000 << 16)};
      end
      REG_PRINCIPAL_POINT: begin
        return {span(0, 1000 << 16), span(0, 1000 << 16)};
      end
      default: begin
        return {span(-(1 << 23), 1 << 23), span(-(1 << 23), 1 << 23)};
      end
    endcase
  endfunction

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 7))
      0, 1:    return $urandom;
      2:       return edge_vals[$urandom_range(0, 7)];
      default: return span(-(60 << 16), 60 << 16);
    endcase
  endfunction

  // Consume pixels with random stalls
  initial begin
    int gap;
    out_ch.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = idle_on ? $urandom_range(0, 8) : 0;
      repeat (gap) begin
        @(negedge clk);
        out_ch.ready <= 1'b0;
      end
      @(negedge clk);
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      sb.check_pixel(out_ch.pixel_u, out_ch.pixel_v, out_ch.depth_clamped);
    end
  end

  // Abort when nothing moves for too long
  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready) || !rst_n) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout after %0d idle cycles", quiet_cycles);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    logic [63:0] d;
    sb = new();
    idle_on = 1'b1;
    settings = 1;
    edge_vals = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0, -32'sd1, 32'sd1,
                  32'sh0001_0000, -32'sh0001_0000, 32'sh5555_AAAA};
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.point_x = '0;
    in_ch.point_y = '0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.index  = '0;
    cfg_ch.data   = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed corners on the reset camera
    for (int i = 0; i < 8; i++) send_point(edge_vals[i], edge_vals[7 - i]);
    send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_point(32'sh8000_0000, 32'sh8000_0000);
    drain();

    // Out-of-range indexes must leave the camera alone
    write_reg(IDX_PAST_END, '1);
    write_reg(IDX_TOP, '1);
    send_point(32'sh0003_0000, -32'sh0002_0000);
    drain();

    // Zero depth everywhere: flat third row, tz of zero
    write_reg(REG_ROT_B, 64'h0);
    write_reg(REG_ROT_C, 64'h4000_0000_0000_0000);
    write_reg(REG_TRANS_Z_FOCAL_X, 64'h0000_0000_0001_0000);
    write_reg(REG_RADIAL_COEFFS, 64'h0100_0000_FF00_0000);
    settings++;
    send_point(32'sh0, 32'sh0);
    send_point(32'sd1, -32'sd1);
    send_point(32'sh7FFF_FFFF, 32'sh8000_0000);
    send_point(-32'sh0001_0000, 32'sh0001_0000);
    drain();

    // Random phases with fresh camera setups
    for (int ph = 0; ph < 10; ph++) begin
      idle_on = (ph % 3 != 1);
      for (int r = 0; r < NUM_REGS; r++) begin
        case (ph)
          0:       d = 64'h7FFF_FFFF_8000_0000;
          1:       d = '1;
          2:       d = '0;
          3:       d = 64'h8000_0000_7FFF_FFFF;
          default: d = ($urandom_range(0, 4) == 0) ? {$urandom, $urandom} : camera_reg(r);
        endcase
        write_reg(CFG_IDX_W'(r), d);
      end
      settings++;
      for (int i = 0; i < 112; i++) begin
        // hold the stream once per phase until the pipe has emptied
        if (i == 57) begin
          drain();
        end
        send_point(rand_coord(), rand_coord());
      end
      drain();
    end

    $display("Projected %0d points under %0d camera setups, %0d with zero depth.",
             sb.points, settings, sb.clamps);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
